[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the text renderer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ttp_pkg.sv]
// ----------------------------------------------------------------------------
// ttp_pkg
// Types, constants, font ROM and microcode for the text renderer.
// ----------------------------------------------------------------------------
package ttp_pkg;

	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT     = DISPLAY_HEIGHT / 8;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] GLYPH_DEFAULT = 8'h5F;
	localparam logic [7:0] BLANK_BYTE    = 8'h00;

	localparam int GLYPH_COUNT   = 16;
	localparam int GLYPH_MAX_COL = 6;

	localparam logic [2:0] GLYPH_WIDTH [GLYPH_COUNT] = '{
		3'd3, 3'd1, 3'd3, 3'd5, 3'd4, 3'd6, 3'd5, 3'd1,
		3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd1, 3'd4
	};

	localparam logic [7:0] GLYPH_BITS [GLYPH_COUNT][GLYPH_MAX_COL] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h03, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00},
		'{8'h28, 8'h7F, 8'h14, 8'h7F, 8'h0A, 8'h00},
		'{8'h24, 8'h2A, 8'h6B, 8'h12, 8'h00, 8'h00},
		'{8'h20, 8'h13, 8'h0B, 8'h68, 8'h64, 8'h02},
		'{8'h36, 8'h49, 8'h56, 8'h20, 8'h50, 8'h00},
		'{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3E, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h05, 8'h02, 8'h05, 8'h00, 8'h00, 8'h00},
		'{8'h08, 8'h1C, 8'h08, 8'h00, 8'h00, 8'h00},
		'{8'h40, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h08, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00},
		'{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h40, 8'h30, 8'h0C, 8'h03, 8'h00, 8'h00}
	};

	// Glyph width in columns for a printable code.
	function automatic logic [2:0] glyph_width(input logic [7:0] ch);
		logic [7:0] g;
		g = ch - CH_SPACE;
		if (g < 8'(GLYPH_COUNT)) begin
			return GLYPH_WIDTH[g[3:0]];
		end
		return 3'd1;
	endfunction

	// One column of a glyph.
	function automatic logic [7:0] glyph_byte(input logic [7:0] ch, input logic [2:0] idx);
		logic [7:0] g;
		g = ch - CH_SPACE;
		if (g >= 8'(GLYPH_COUNT)) begin
			return GLYPH_DEFAULT;
		end
		if (idx < 3'(GLYPH_MAX_COL)) begin
			return GLYPH_BITS[g[3:0]][idx];
		end
		return BLANK_BYTE;
	endfunction

	// Datapath operations selected by the microcode.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_DISPATCH,
		OP_NEWLINE,
		OP_GLYPH,
		OP_TAIL,
		OP_BLANK,
		OP_NOP
	} op_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_DRAW,
		COND_MORE,
		COND_DONE
	} cond_t;

	localparam int STEP_W     = 3;
	localparam int UCODE_SIZE = 8;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  emits;
	} ucw_t;

	localparam step_t ST_IDLE  = 3'd0;
	localparam step_t ST_GLYPH = 3'd4;
	localparam step_t ST_BLANK = 3'd6;

	// Control program: a true condition jumps to target, else the next step.
	localparam ucw_t UCODE [UCODE_SIZE] = '{
		'{op: OP_IDLE,     cond: COND_NO_INPUT, target: ST_IDLE,  emits: 1'b0},
		'{op: OP_LOAD,     cond: COND_ALWAYS,   target: 3'd2,     emits: 1'b0},
		'{op: OP_DISPATCH, cond: COND_DRAW,     target: ST_GLYPH, emits: 1'b0},
		'{op: OP_NEWLINE,  cond: COND_ALWAYS,   target: ST_BLANK, emits: 1'b0},
		'{op: OP_GLYPH,    cond: COND_MORE,     target: ST_GLYPH, emits: 1'b1},
		'{op: OP_TAIL,     cond: COND_DONE,     target: ST_IDLE,  emits: 1'b1},
		'{op: OP_BLANK,    cond: COND_ALWAYS,   target: ST_IDLE,  emits: 1'b1},
		'{op: OP_NOP,      cond: COND_ALWAYS,   target: ST_IDLE,  emits: 1'b0}
	};

	// Sequencer to datapath.
	typedef struct packed {
		op_t  op;
		logic go;
	} ctl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic in_accept;
		logic draw;
		logic more;
		logic done;
		logic slot_free;
	} sts_t;

endpackage

[hdl/ttp_in_if.sv]
// ----------------------------------------------------------------------------
// ttp_in_if
// Character request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic [2:0] start_page;
	logic [6:0] start_column;
	logic       first_of_string;
	logic       last_of_string;

	modport source (
		output valid, character, start_page, start_column, first_of_string, last_of_string,
		input  ready
	);
	modport sink (
		input  valid, character, start_page, start_column, first_of_string, last_of_string,
		output ready
	);
endinterface

[hdl/ttp_out_if.sv]
// ----------------------------------------------------------------------------
// ttp_out_if
// Framebuffer write request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttp_out_if;
	logic       valid;
	logic       ready;
	logic       write_valid;
	logic [2:0] page;
	logic [6:0] column;
	logic [7:0] pixel_byte;
	logic       halted;
	logic       refresh_request;
	logic       last_of_run;

	modport source (
		output valid, write_valid, page, column, pixel_byte, halted, refresh_request,
		       last_of_run,
		input  ready
	);
	modport sink (
		input  valid, write_valid, page, column, pixel_byte, halted, refresh_request,
		       last_of_run,
		output ready
	);
endinterface

[hdl/text_to_page_framebuffer_renderer.sv]
// ----------------------------------------------------------------------------
// text_to_page_framebuffer_renderer
// Renders a string, one character per request, into page-mode framebuffer
// byte write requests using a proportional bitmap font.
// ----------------------------------------------------------------------------
// The block accepts one character request at a time on text and answers with
// one or more write requests on pixels, the final one marked by last_of_run.
// A printable character produces its glyph columns (one to six), followed by a
// blank gap column unless it reaches the right edge, one write per cycle;
// columns past the display width are dropped and the cursor wraps to the start
// column on the next page. A newline, a skipped control code or a halted
// string produces a single request with write_valid low. A character is taken
// in the idle step of the control program and passes its load and dispatch
// steps; a drawn character then steps through its glyph columns and the gap
// step, any other character through the newline and blank steps. A glyph that
// lies wholly past the right edge adds the blank step, for its no-write
// result. Every step that writes also waits while the output register still
// holds a request that the sink has not taken. The next character is taken
// only when the program has returned to its idle step. The output register
// lets the program finish and take the next character while the last write
// request still waits for the sink. The first character of a string, marked by
// first_of_string, loads the cursor and wrap column from start_page and
// start_column and clears the halt; refresh_request is raised on the final
// request of the last character when the string has not left the last page.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_to_page_framebuffer_renderer
	import ttp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ttp_in_if.sink    text,
	ttp_out_if.source pixels
);

	// Control word for the current step and status fed back to the jumps.
	ctl_t ctl;
	sts_t sts;

	// Step counter and microcode ROM.
	ttp_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// Cursor, font lookup and output register.
	ttp_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.text   (text),
		.pixels (pixels)
	);

	// An accepted character always starts the program at its load step.
	`ASSERT_NEXT(a_accept_loads, clk, arst_n, text.valid && text.ready, ctl.op == OP_LOAD, "accepted character did not start the load step")

	// A refresh is only asked on the closing request of a string that did not halt.
	`ASSERT_IMPLY(a_refresh_last, clk, arst_n, pixels.valid && pixels.refresh_request, pixels.last_of_run && !pixels.halted, "refresh request outside the closing request")

	// A request without a write is always the only, and so the final, one of its character.
	`ASSERT_IMPLY(a_blank_last, clk, arst_n, pixels.valid && !pixels.write_valid, pixels.last_of_run, "no-write request not marked last")

endmodule

[hdl/ttp_useq.sv]
// ----------------------------------------------------------------------------
// ttp_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module ttp_useq
	import ttp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl
);

	step_t step_q;
	ucw_t  cw;
	logic  stall;
	logic  take;

	assign cw    = UCODE[step_q];
	assign stall = cw.emits && !sts.slot_free;

	always_comb begin
		unique case (cw.cond)
			COND_ALWAYS:   take = 1'b1;
			COND_NO_INPUT: take = !sts.in_accept;
			COND_DRAW:     take = sts.draw;
			COND_MORE:     take = sts.more;
			COND_DONE:     take = sts.done;
			default:       take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (!stall) begin
			step_q <= take ? cw.target : step_q + 3'd1;
		end
	end

	assign ctl.op = cw.op;
	assign ctl.go = !stall;

endmodule

[hdl/ttp_dpath.sv]
// ----------------------------------------------------------------------------
// ttp_dpath
// Cursor, glyph column datapath and output register of the text renderer.
// ----------------------------------------------------------------------------
module ttp_dpath
	import ttp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl,
	output sts_t    sts,
	ttp_in_if.sink  text,
	ttp_out_if.source pixels
);

	// Captured request.
	logic [7:0] char_q;
	logic [2:0] spage_q;
	logic [6:0] scol_q;
	logic       first_q;
	logic       last_q;

	// Cursor state and per-glyph control.
	logic [2:0] page_q;
	logic [7:0] col_q;
	logic [6:0] wrap_q;
	logic       halt_q;
	logic [2:0] w_q;
	logic [2:0] idx_q;
	logic       wraps_q;
	logic       wrote_q;

	// Output register.
	logic       out_valid_q;
	logic       o_write_q;
	logic [2:0] o_page_q;
	logic [6:0] o_col_q;
	logic [7:0] o_byte_q;
	logic       o_halt_q;
	logic       o_refresh_q;
	logic       o_last_q;

	logic       in_accept;
	logic       draw;
	logic [2:0] w_glyph;
	logic [8:0] prep_sum;
	logic       prep_wraps;
	logic       last_page;
	logic [8:0] col_idx;
	logic [8:0] sum_w;
	logic       in_range;
	logic       emit_now;
	logic       r_write;
	logic [6:0] r_col;
	logic [7:0] r_byte;
	logic       r_last;

	assign text.ready = (ctl.op == OP_IDLE);
	assign in_accept  = text.valid && text.ready;

	assign draw       = !halt_q && (char_q >= CH_SPACE) && (char_q <= CH_TILDE);
	assign w_glyph    = glyph_width(char_q);
	assign prep_sum   = {1'b0, col_q} + 9'(w_glyph);
	assign prep_wraps = prep_sum >= 9'(DISPLAY_WIDTH);
	assign last_page  = ({1'b0, page_q} + 4'd1) >= 4'(PAGE_COUNT);
	assign col_idx    = {1'b0, col_q} + 9'(idx_q);
	assign sum_w      = {1'b0, col_q} + 9'(w_q);
	assign in_range   = col_idx < 9'(DISPLAY_WIDTH);

	assign sts.in_accept = in_accept;
	assign sts.draw      = draw;
	assign sts.more      = ({1'b0, idx_q} + 4'd1) < {1'b0, w_q};
	assign sts.done      = !wraps_q || wrote_q;
	assign sts.slot_free = !out_valid_q || pixels.ready;

	// A dropped column or a wrapping tail produces no result.
	assign emit_now = ctl.go && (((ctl.op == OP_GLYPH) && in_range)
		|| ((ctl.op == OP_TAIL) && !wraps_q) || (ctl.op == OP_BLANK));

	always_comb begin
		r_write = 1'b0;
		r_col   = 7'd0;
		r_byte  = BLANK_BYTE;
		r_last  = 1'b1;
		unique case (ctl.op)
			OP_GLYPH: begin
				r_write = 1'b1;
				r_col   = col_idx[6:0];
				r_byte  = glyph_byte(char_q, idx_q);
				// Last write of a wrapping glyph is its last column on the display.
				r_last  = wraps_q && ((col_idx + 9'd1) >= 9'(DISPLAY_WIDTH));
			end
			OP_TAIL: begin
				r_write = 1'b1;
				r_col   = sum_w[6:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_q  <= text.character;
			spage_q <= text.start_page;
			scol_q  <= text.start_column;
			first_q <= text.first_of_string;
			last_q  <= text.last_of_string;
		end
		if (emit_now) begin
			o_write_q   <= r_write;
			o_page_q    <= r_write ? page_q : 3'd0;
			o_col_q     <= r_col;
			o_byte_q    <= r_byte;
			o_halt_q    <= halt_q;
			o_refresh_q <= r_last && last_q && !halt_q;
			o_last_q    <= r_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q      <= 3'd0;
			col_q       <= 8'd0;
			wrap_q      <= 7'd0;
			halt_q      <= 1'b0;
			w_q         <= 3'd0;
			idx_q       <= 3'd0;
			wraps_q     <= 1'b0;
			wrote_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.go) begin
				unique case (ctl.op)
					OP_LOAD: begin
						if (first_q) begin
							page_q <= spage_q;
							col_q  <= {1'b0, scol_q};
							wrap_q <= scol_q;
							halt_q <= {1'b0, spage_q} >= 4'(PAGE_COUNT);
						end
					end
					OP_DISPATCH: begin
						if (draw) begin
							w_q     <= w_glyph;
							wraps_q <= prep_wraps;
							idx_q   <= 3'd0;
							wrote_q <= 1'b0;
							// Halt known up front so every write of the glyph reports it.
							if (prep_wraps && last_page) begin
								halt_q <= 1'b1;
							end
						end
					end
					OP_NEWLINE: begin
						if ((char_q == CH_NEWLINE) && !halt_q) begin
							col_q <= {1'b0, wrap_q};
							if (last_page) begin
								halt_q <= 1'b1;
							end else begin
								page_q <= page_q + 3'd1;
							end
						end
					end
					OP_GLYPH: begin
						idx_q <= idx_q + 3'd1;
						if (in_range) begin
							wrote_q <= 1'b1;
						end
					end
					OP_TAIL: begin
						if (wraps_q) begin
							col_q <= {1'b0, wrap_q};
							if (!last_page) begin
								page_q <= page_q + 3'd1;
							end
						end else begin
							col_q <= 8'(sum_w + 9'd1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign pixels.valid           = out_valid_q;
	assign pixels.write_valid     = o_write_q;
	assign pixels.page            = o_page_q;
	assign pixels.column          = o_col_q;
	assign pixels.pixel_byte      = o_byte_q;
	assign pixels.halted          = o_halt_q;
	assign pixels.refresh_request = o_refresh_q;
	assign pixels.last_of_run     = o_last_q;

endmodule

[verif/tb_text_to_page_framebuffer_renderer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_to_page_framebuffer_renderer
// Self-checking bench for the bitmap font text renderer. Character requests
// are sent from a directed table and then as random strings. A local model of
// the cursor and the font predicts every framebuffer write request. Each
// request that leaves the block is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_text_to_page_framebuffer_renderer;
	import ttp_pkg::DISPLAY_WIDTH;
	import ttp_pkg::PAGE_COUNT;

	// Character codes that steer the renderer.
	localparam logic [7:0] CODE_NEWLINE     = 8'h0A;
	localparam logic [7:0] CODE_FIRST_PRINT = 8'h20;
	localparam logic [7:0] CODE_LAST_PRINT  = 8'h7E;
	localparam logic [7:0] CODE_FIRST_HIGH  = 8'h7F;
	localparam logic [7:0] CODE_NUL         = 8'h00;
	localparam logic [7:0] CODE_CTRL_LAST   = 8'h1F;
	localparam logic [7:0] CODE_HIGH_LAST   = 8'hFF;

	// Every code from '0' to '~' draws this single column.
	localparam logic [7:0] PLAIN_GLYPH_COLUMN = 8'h5F;
	localparam int         OWN_GLYPHS         = 16;

	localparam int RANDOM_ITEMS    = 400;
	localparam int IDLE_PERCENT    = 8;
	localparam int HOLD_OFF_AFTER  = 150;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 20;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int REPORT_LIMIT    = 10;

	// Widths and column bytes of the glyphs from space to slash.
	localparam logic [2:0] FONT_WIDTH [OWN_GLYPHS] = '{
		3'd3, 3'd1, 3'd3, 3'd5, 3'd4, 3'd6, 3'd5, 3'd1,
		3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd1, 3'd4
	};
	localparam logic [7:0] FONT_COLUMNS [OWN_GLYPHS][6] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h03, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00},
		'{8'h28, 8'h7F, 8'h14, 8'h7F, 8'h0A, 8'h00},
		'{8'h24, 8'h2A, 8'h6B, 8'h12, 8'h00, 8'h00},
		'{8'h20, 8'h13, 8'h0B, 8'h68, 8'h64, 8'h02},
		'{8'h36, 8'h49, 8'h56, 8'h20, 8'h50, 8'h00},
		'{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3E, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h41, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h05, 8'h02, 8'h05, 8'h00, 8'h00, 8'h00},
		'{8'h08, 8'h1C, 8'h08, 8'h00, 8'h00, 8'h00},
		'{8'h40, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h08, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00},
		'{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h40, 8'h30, 8'h0C, 8'h03, 8'h00, 8'h00}
	};

	typedef struct packed {
		logic [7:0] character;
		logic [2:0] start_page;
		logic [6:0] start_column;
		logic       first_of_string;
		logic       last_of_string;
	} char_req_t;

	typedef struct packed {
		logic       write_valid;
		logic [2:0] page;
		logic [6:0] column;
		logic [7:0] pixel_byte;
		logic       halted;
		logic       refresh_request;
		logic       last_of_run;
	} fb_write_t;

	// A directed row either carries its single result typed in, or leaves the
	// result to the local model (typed low).
	typedef struct packed {
		char_req_t req;
		logic      typed;
		fb_write_t result;
	} directed_row_t;

	localparam fb_write_t NO_WRITE      = '{1'b0, 3'd0, 7'd0, 8'h00, 1'b0, 1'b0, 1'b1};
	localparam fb_write_t NO_WRITE_HALT = '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b0, 1'b1};
	localparam fb_write_t NO_WRITE_DONE = '{1'b0, 3'd0, 7'd0, 8'h00, 1'b0, 1'b1, 1'b1};
	localparam fb_write_t MODEL_ONLY    = '0;

	localparam int DIRECTED_COUNT = 22;

	// The directed part walks through skipped codes at both ends of the byte
	// range, every glyph shape class, the right-hand edge, newlines, the last
	// page and the halt, and requests that arrive while the string is halted.
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{'{CODE_NUL,       3'd0, 7'd0,   1'b0, 1'b0}, 1'b1, NO_WRITE},
		'{'{CODE_HIGH_LAST, 3'd0, 7'd0,   1'b1, 1'b0}, 1'b1, NO_WRITE},
		'{'{CODE_FIRST_HIGH, 3'd5, 7'd64, 1'b0, 1'b0}, 1'b1, NO_WRITE},
		'{'{CODE_CTRL_LAST, 3'd2, 7'd9,   1'b0, 1'b0}, 1'b1, NO_WRITE},
		'{'{8'h20,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{8'h21,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{8'h23,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{8'h25,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{8'h26,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{8'h2F,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{8'h30,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{CODE_LAST_PRINT, 3'd0, 7'd0,  1'b0, 1'b1}, 1'b0, MODEL_ONLY},
		'{'{8'h21,          3'd3, 7'd127, 1'b1, 1'b1}, 1'b1,
			'{1'b1, 3'd3, 7'd127, PLAIN_GLYPH_COLUMN, 1'b0, 1'b1, 1'b1}},
		'{'{8'h25,          3'd0, 7'd125, 1'b1, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{CODE_NEWLINE,   3'd7, 7'd127, 1'b1, 1'b1}, 1'b1, NO_WRITE_HALT},
		'{'{8'h41,          3'd0, 7'd0,   1'b0, 1'b1}, 1'b1, NO_WRITE_HALT},
		'{'{CODE_NEWLINE,   3'd6, 7'd0,   1'b1, 1'b0}, 1'b1, NO_WRITE},
		'{'{8'h25,          3'd0, 7'd0,   1'b0, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{CODE_NEWLINE,   3'd0, 7'd0,   1'b0, 1'b1}, 1'b1, NO_WRITE_HALT},
		'{'{8'h30,          3'd7, 7'd126, 1'b1, 1'b0}, 1'b0, MODEL_ONLY},
		'{'{8'h2F,          3'd0, 7'd0,   1'b0, 1'b1}, 1'b1, NO_WRITE_HALT},
		'{'{CODE_NEWLINE,   3'd0, 7'd0,   1'b1, 1'b1}, 1'b1, NO_WRITE_DONE}
	};

	logic clk;
	logic arst_n;

	ttp_in_if  text ();
	ttp_out_if pixels ();

	text_to_page_framebuffer_renderer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.pixels (pixels)
	);

	// Local copy of the renderer state: the pen position, the column that a
	// new line returns to, and whether the string has run off the display.
	logic [2:0] pen_page;
	logic [7:0] pen_column;
	logic [6:0] margin_column;
	logic       string_stopped;

	fb_write_t rendered [$];        // writes of the character just rendered
	fb_write_t pending_writes [$];  // writes still owed by the block

	int  requests_sent;
	int  writes_checked;
	int  mismatch_count;
	int  cycle_count;
	bit  calm_window;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The run must never get stuck; a hung handshake ends it here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_text_to_page_framebuffer_renderer: errors");
		$finish;
	end

	// Moves the pen to the margin of the next page, or stops the string when
	// the last page is left behind. The page itself stays put in that case.
	function automatic void advance_line();
		pen_column = {1'b0, margin_column};
		if (int'(pen_page) + 1 >= PAGE_COUNT) begin
			string_stopped = 1'b1;
		end else begin
			pen_page = pen_page + 3'd1;
		end
	endfunction

	function automatic fb_write_t make_write(input logic [2:0] pg, input int col,
		input logic [7:0] bits);
		fb_write_t w;
		w = '0;
		w.write_valid = 1'b1;
		w.page        = pg;
		w.column      = col[6:0];
		w.pixel_byte  = bits;
		return w;
	endfunction

	// Renders one character request into the writes that the block owes for
	// it, leaving them in rendered[] and updating the local pen state.
	function automatic void render_character(input char_req_t req);
		int         glyph;
		int         width;
		int         col;
		logic [7:0] bits;
		rendered.delete();
		if (req.first_of_string) begin
			pen_page       = req.start_page;
			pen_column     = {1'b0, req.start_column};
			margin_column  = req.start_column;
			string_stopped = (int'(req.start_page) >= PAGE_COUNT);
		end
		if (!string_stopped) begin
			if (req.character == CODE_NEWLINE) begin
				advance_line();
			end else if (req.character >= CODE_FIRST_PRINT
					&& req.character <= CODE_LAST_PRINT) begin
				glyph = int'(req.character - CODE_FIRST_PRINT);
				width = (glyph < OWN_GLYPHS) ? int'(FONT_WIDTH[glyph]) : 1;
				for (int i = 0; i < width; i++) begin
					col  = int'(pen_column) + i;
					bits = (glyph < OWN_GLYPHS) ? FONT_COLUMNS[glyph][i]
						: PLAIN_GLYPH_COLUMN;
					// Columns past the right edge are dropped, not wrapped.
					if (col < DISPLAY_WIDTH) begin
						rendered.push_back(make_write(pen_page, col, bits));
					end
				end
				pen_column = pen_column + 8'(width);
				if (int'(pen_column) >= DISPLAY_WIDTH) begin
					advance_line();
				end else begin
					rendered.push_back(make_write(pen_page, int'(pen_column), 8'h00));
					pen_column = pen_column + 8'd1;
				end
			end
		end
		// Newlines, skipped codes and halted strings still answer once.
		if (rendered.size() == 0) begin
			rendered.push_back('0);
		end
		foreach (rendered[k]) begin
			rendered[k].halted = string_stopped;
		end
		rendered[rendered.size() - 1].refresh_request =
			req.last_of_string && !string_stopped;
		rendered[rendered.size() - 1].last_of_run = 1'b1;
	endfunction

	function automatic string describe(input fb_write_t w);
		return $sformatf("wv=%0d page=%0d col=%0d byte=%02h halt=%0d refresh=%0d last=%0d",
			w.write_valid, w.page, w.column, w.pixel_byte, w.halted,
			w.refresh_request, w.last_of_run);
	endfunction

	// Offers one character request, waits for the block to take it, and then
	// records what the block owes in return. A typed row replaces the model's
	// answer with the one written in the table.
	task automatic offer_request(input char_req_t req, input logic typed,
		input fb_write_t typed_result);
		// The sender goes quiet now and then, except in the calm window.
		calm_window = (requests_sent >= 300 && requests_sent < 380);
		if (!calm_window && $urandom_range(99) < IDLE_PERCENT) begin
			text.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		text.valid           <= 1'b1;
		text.character       <= req.character;
		text.start_page      <= req.start_page;
		text.start_column    <= req.start_column;
		text.first_of_string <= req.first_of_string;
		text.last_of_string  <= req.last_of_string;
		@(posedge clk);
		while (!text.ready) @(posedge clk);
		requests_sent++;
		render_character(req);
		if (typed) begin
			pending_writes.push_back(typed_result);
		end else begin
			foreach (rendered[k]) pending_writes.push_back(rendered[k]);
		end
	endtask

	// Picks a character: mostly drawn glyphs, with newlines, control codes
	// and high codes mixed in.
	function automatic logic [7:0] pick_character();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45) return CODE_FIRST_PRINT + 8'($urandom_range(OWN_GLYPHS - 1));
		if (roll < 70) return 8'($urandom_range(8'h30, CODE_LAST_PRINT));
		if (roll < 82) return CODE_NEWLINE;
		if (roll < 91) return 8'($urandom_range(CODE_NUL, CODE_CTRL_LAST));
		return 8'($urandom_range(CODE_FIRST_HIGH, CODE_HIGH_LAST));
	endfunction

	// Sink side: checks every write request taken from the block and drives
	// ready. Once, after a good number of requests, it holds off for a long
	// stretch so that the block backs up and stops taking characters.
	initial begin
		int        holdoff_left;
		bit        holdoff_done;
		fb_write_t got;
		fb_write_t want;
		holdoff_left = 0;
		holdoff_done = 0;
		pixels.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pixels.valid && pixels.ready) begin
				got = '{pixels.write_valid, pixels.page, pixels.column,
					pixels.pixel_byte, pixels.halted, pixels.refresh_request,
					pixels.last_of_run};
				writes_checked++;
				if (pending_writes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("unexpected write request: %s", describe(got));
					end
				end else begin
					want = pending_writes.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("write mismatch at cycle %0d", cycle_count);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end
			if (!holdoff_done && writes_checked >= HOLD_OFF_AFTER) begin
				holdoff_done = 1;
				holdoff_left = HOLD_OFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				pixels.ready <= 1'b0;
			end else begin
				pixels.ready <= calm_window || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Source side: reset, the directed table, random strings, then the drain.
	initial begin
		char_req_t req;
		int        length;
		int        noise_left;
		arst_n               <= 1'b0;
		text.valid           <= 1'b0;
		text.character       <= CODE_NUL;
		text.start_page      <= 3'd0;
		text.start_column    <= 7'd0;
		text.first_of_string <= 1'b0;
		text.last_of_string  <= 1'b0;
		requests_sent  = 0;
		writes_checked = 0;
		mismatch_count = 0;
		calm_window    = 0;
		pen_page       = 3'd0;
		pen_column     = 8'd0;
		margin_column  = 7'd0;
		string_stopped = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			offer_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed,
				DIRECTED_ROWS[r].result);
		end

		// Random part: mostly whole strings that start with a first request
		// and end with a last one, so that the cursor travels across pages
		// and reaches the halt. The rest is raw noise and strings that simply
		// carry on from where the previous one left the cursor.
		while (requests_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
			if ($urandom_range(99) < 12) begin
				noise_left = $urandom_range(1, 3);
				for (int n = 0; n < noise_left; n++) begin
					req = char_req_t'($urandom);
					offer_request(req, 1'b0, MODEL_ONLY);
				end
			end else begin
				length = $urandom_range(1, 14);
				for (int i = 0; i < length; i++) begin
					req.character       = pick_character();
					req.start_page      = 3'($urandom_range(7));
					req.start_column    = ($urandom_range(1)) ? 7'($urandom_range(127))
						: 7'($urandom_range(96, 127));
					req.first_of_string = (i == 0) && ($urandom_range(99) < 90);
					req.last_of_string  = (i == length - 1);
					offer_request(req, 1'b0, MODEL_ONLY);
				end
			end
		end
		text.valid <= 1'b0;

		while (pending_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_writes.size() == 0) begin
			$display("tb_text_to_page_framebuffer_renderer: clean");
		end else begin
			$display("tb_text_to_page_framebuffer_renderer: errors");
		end
		$finish;
	end

endmodule
